// ===== src/rggrh_pkg.sv =====
// Shared types and constants for the radar gate ground range and height block
`default_nettype none
package rggrh_pkg;

   localparam int unsigned STEP_W = 5;

   // CORDIC arctangent table, binary angle with 2^32 per full turn
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;
   localparam logic signed [32:0] TWO_PI_Q28   = 33'sd1686629713;
   localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
   // angle scaling: 2^27 = DIV_HI*1125 + DIV_LO, half of 36000/32 rounded down is DIV_BIAS,
   // and DIV_RCP/2^32 stands for 1/1125
   localparam logic [16:0]        DIV_HI       = 17'd119304;
   localparam logic [9:0]         DIV_LO       = 10'd728;
   localparam logic [9:0]         DIV_BIAS     = 10'd562;
   localparam logic [21:0]        DIV_RCP      = 22'd3817749;
   localparam logic signed [14:0] ELEV_MAX     = 15'sd9000;
   localparam logic signed [14:0] ELEV_MIN     = -15'sd9000;
   localparam logic [23:0]        MAX_U24      = 24'hFFFFFF;

   localparam logic [1:0] CSR_EARTH_RADIUS = 2'd0;
   localparam logic [1:0] CSR_GATE_SPACING = 2'd1;
   localparam logic [1:0] CSR_FIRST_GATE   = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_VERT,
      OP_DIV_MUL,
      OP_DIV_RCP,
      OP_SC_INIT,
      OP_SC_STEP,
      OP_MULX,
      OP_MULY,
      OP_ROUNDY,
      OP_VEC_INIT,
      OP_VEC_STEP,
      OP_MAG,
      OP_ANG,
      OP_TRND,
      OP_GR,
      OP_FIN
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [STEP_W-1:0]   step;
   } cmd_type;

   typedef struct packed {
      logic zero_slant;
      logic vertical;
      logic origin;
   } status_type;

endpackage
`default_nettype wire

// ===== src/radar_gate_ground_range_height.sv =====
// Top level: radar gate slant range, ground range and height under an effective earth
// Steps per beat: check, angle scaling, rotation, products, vectoring and finish;
//   zero slant range goes straight to finish, vertical beam skips scaling and rotation.
// Throughput: one item at a time, a new beat taken once the result is raised; the two
//   CORDIC passes through one shared rotator set the period, and a stalled result holds it.
// Reset: synchronous, active high; clears the sequencer and result valid, loads the
//   configuration registers with their defaults. No clearing pass.
`default_nettype none
module radar_gate_ground_range_height import rggrh_pkg::*; #(
   parameter int unsigned GATE_COUNT   = 4096,
   parameter int unsigned CORDIC_STEPS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [11:0]        req_gate_index,
   input  wire logic signed [14:0] req_elevation_cdeg,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [23:0]             rsp_slant_range_m,
   output logic [23:0]             rsp_ground_range_m,
   output logic signed [23:0]      rsp_height_m,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_wdata
);

   // configuration registers; write them only while no item is in flight
   logic [23:0] earth_radius_ff;
   logic [10:0] gate_spacing_ff;
   logic [16:0] first_gate_ff;

   cmd_type    cmd;
   status_type status;

   // always take a configuration beat
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         earth_radius_ff <= 24'd8498667;
         gate_spacing_ff <= 11'd250;
         first_gate_ff   <= 17'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_EARTH_RADIUS: earth_radius_ff <= csr_wdata;
            CSR_GATE_SPACING: gate_spacing_ff <= csr_wdata[10:0];
            CSR_FIRST_GATE:   first_gate_ff   <= csr_wdata[16:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // sequencer: steps the datapath through angle scaling, rotation, products and vectoring
   rggrh_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: holds the item, result registers double as the output stage
   rggrh_dp #(
      .GATE_COUNT(GATE_COUNT)
   ) u_dp (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .gate_index         (req_gate_index),
      .elevation_cdeg     (req_elevation_cdeg),
      .earth_radius_m     (earth_radius_ff),
      .gate_spacing_m     (gate_spacing_ff),
      .first_gate_range_m (first_gate_ff),
      .slant_range_m      (rsp_slant_range_m),
      .ground_range_m     (rsp_ground_range_m),
      .height_m           (rsp_height_m)
   );

endmodule
`default_nettype wire

// ===== src/rggrh_ctrl.sv =====
// Sequencer for the gate geometry datapath
`default_nettype none
module rggrh_ctrl import rggrh_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = 24
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_CHECK  = 15'b000000000000010,
      S_DIV    = 15'b000000000000100,
      S_SCINIT = 15'b000000000001000,
      S_SC     = 15'b000000000010000,
      S_MULX   = 15'b000000000100000,
      S_MULY   = 15'b000000001000000,
      S_ROUNDY = 15'b000000010000000,
      S_CHKO   = 15'b000000100000000,
      S_VEC    = 15'b000001000000000,
      S_MAG    = 15'b000010000000000,
      S_ANG    = 15'b000100000000000,
      S_T      = 15'b001000000000000,
      S_GR     = 15'b010000000000000,
      S_FIN    = 15'b100000000000000
   } state_type;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.op       = OP_NONE;
      cmd.step     = cnt_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cnt_in = '0;
            if (status.zero_slant) begin
               state_in = S_FIN;
            end else if (status.vertical) begin
               cmd.op   = OP_VERT;
               state_in = S_MULX;
            end else begin
               cmd.op   = OP_DIV_MUL;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op   = OP_DIV_RCP;
            state_in = S_SCINIT;
         end
         S_SCINIT: begin
            cmd.op   = OP_SC_INIT;
            cnt_in   = '0;
            state_in = S_SC;
         end
         S_SC: begin
            cmd.op = OP_SC_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            cmd.op   = OP_MULX;
            state_in = S_MULY;
         end
         S_MULY: begin
            cmd.op   = OP_MULY;
            state_in = S_ROUNDY;
         end
         S_ROUNDY: begin
            cmd.op   = OP_ROUNDY;
            state_in = S_CHKO;
         end
         S_CHKO: begin
            cnt_in = '0;
            if (status.origin) begin
               state_in = S_FIN;
            end else begin
               cmd.op   = OP_VEC_INIT;
               state_in = S_VEC;
            end
         end
         S_VEC: begin
            cmd.op = OP_VEC_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            cmd.op   = OP_MAG;
            state_in = S_ANG;
         end
         S_ANG: begin
            cmd.op   = OP_ANG;
            state_in = S_T;
         end
         S_T: begin
            cmd.op   = OP_TRND;
            state_in = S_GR;
         end
         S_GR: begin
            cmd.op   = OP_GR;
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_FIN;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHECK))
      else $error("accepted beat did not move to the check step");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("result raised outside the finish step");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_FIN))
      else $error("finish step overwrote a pending result");

   a_vec_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VEC || state_ff == S_SC) |-> (cnt_ff <= LAST_STEP))
      else $error("CORDIC step count ran past the last step");

endmodule
`default_nettype wire

// ===== src/rggrh_dp.sv =====
// Datapath: slant range, angle scaling, shared CORDIC and shared multiplier
`default_nettype none
module rggrh_dp import rggrh_pkg::*; #(
   parameter int unsigned GATE_COUNT = 4096
) (
   input  wire logic               clock,
   input  wire cmd_type            cmd,
   output status_type              status,
   input  wire logic [11:0]        gate_index,
   input  wire logic signed [14:0] elevation_cdeg,
   input  wire logic [23:0]        earth_radius_m,
   input  wire logic [10:0]        gate_spacing_m,
   input  wire logic [16:0]        first_gate_range_m,
   output logic [23:0]             slant_range_m,
   output logic [23:0]             ground_range_m,
   output logic signed [23:0]      height_m
);

   localparam logic signed [69:0] HALF26 = 70'sd1 <<< 25;
   localparam logic signed [69:0] HALF28 = 70'sd1 <<< 27;
   localparam logic signed [69:0] HALF30 = 70'sd1 <<< 29;
   localparam logic signed [69:0] HALF32 = 70'sd1 <<< 31;

   logic [23:0]        s_ff;
   logic signed [14:0] e_ff;
   logic [22:0]        rem_ff;
   logic [31:0]        quo_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic signed [31:0] x4_ff, y4_ff, hmag_ff;
   logic signed [36:0] t_ff;
   logic signed [69:0] prod_ff;
   logic               origin_ff;

   // load stage
   logic [11:0]        idx_c;
   logic [24:0]        slant_sum;
   logic signed [14:0] e_c;

   always_comb begin
      if ({5'd0, gate_index} >= 17'(GATE_COUNT)) begin
         idx_c = 12'(GATE_COUNT - 1);
      end else begin
         idx_c = gate_index;
      end
      slant_sum = 25'(idx_c) * 25'(gate_spacing_m) + 25'(first_gate_range_m);
      if (elevation_cdeg > ELEV_MAX) begin
         e_c = ELEV_MAX;
      end else if (elevation_cdeg < ELEV_MIN) begin
         e_c = ELEV_MIN;
      end else begin
         e_c = elevation_cdeg;
      end
   end

   // angle scaling, round(|e| * 2^32 / 36000) as a product step then a reciprocal step:
   // |e|*2^27/1125 splits into |e|*DIV_HI plus (|e|*DIV_LO + DIV_BIAS)/1125,
   // and the small quotient comes from a reciprocal product, exact below 2^23
   logic signed [14:0] e_neg;
   logic [13:0]        e_mag;
   logic [30:0]        div_hi;
   logic [22:0]        div_lo;
   logic [44:0]        rcp_p;
   always_comb begin
      e_neg  = -e_ff;
      e_mag  = e_ff[14] ? e_neg[13:0] : e_ff[13:0];
      div_hi = 31'(e_mag) * 31'(DIV_HI);
      div_lo = 23'(e_mag) * 23'(DIV_LO) + 23'(DIV_BIAS);
      rcp_p  = 45'(rem_ff) * 45'(DIV_RCP);
   end

   // CORDIC micro-rotation
   logic signed [33:0] shx, shy, atan_s, qz, va, vb;
   always_comb begin
      shx    = cx_ff >>> cmd.step;
      shy    = cy_ff >>> cmd.step;
      atan_s = signed'({2'b00, ATAN_TAB[cmd.step]});
      qz     = signed'({2'b00, quo_ff});
      va     = 34'(y4_ff);
      vb     = 34'(x4_ff);
   end

   // shared multiplier operands
   logic signed [36:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [69:0] mul_p;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_MULX: begin
            mul_a = signed'({13'd0, s_ff});
            mul_b = signed'(cx_ff[32:0]);
         end
         OP_MULY: begin
            mul_a = signed'({13'd0, s_ff});
            mul_b = signed'(cy_ff[32:0]);
         end
         OP_MAG: begin
            mul_a = 37'(cx_ff);
            mul_b = INV_GAIN_Q30;
         end
         OP_ANG: begin
            mul_a = 37'(cz_ff);
            mul_b = TWO_PI_Q28;
         end
         OP_GR: begin
            mul_a = t_ff;
            mul_b = signed'({9'd0, earth_radius_m});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = 70'(mul_a) * 70'(mul_b);
   end

   // roundings
   logic signed [69:0] x4_full, y4_full, hm_full, t_full, gr_full;
   logic signed [35:0] ht_full;
   logic               origin_in;
   logic [23:0]        gr_sat;
   logic signed [23:0] ht_sat;
   always_comb begin
      x4_full   = (prod_ff + HALF26) >>> 26;
      y4_full   = (signed'({16'd0, earth_radius_m, 30'd0}) + prod_ff + HALF26) >>> 26;
      hm_full   = (prod_ff + HALF30) >>> 30;
      t_full    = (prod_ff + HALF28) >>> 28;
      gr_full   = (prod_ff + HALF32) >>> 32;
      ht_full   = (36'(hmag_ff) - signed'({8'd0, earth_radius_m, 4'd0}) + 36'sd8) >>> 4;
      origin_in = (x4_ff == '0) && (y4_full[31:0] == '0);
      if (gr_full < 70'sd0) begin
         gr_sat = '0;
      end else if (gr_full > 70'sd16777215) begin
         gr_sat = MAX_U24;
      end else begin
         gr_sat = gr_full[23:0];
      end
      if (ht_full > 36'sd8388607) begin
         ht_sat = 24'sh7FFFFF;
      end else if (ht_full < -36'sd8388608) begin
         ht_sat = -24'sh800000;
      end else begin
         ht_sat = ht_full[23:0];
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            s_ff <= slant_sum[24] ? MAX_U24 : slant_sum[23:0];
            e_ff <= e_c;
         end
         OP_VERT: begin
            cx_ff <= '0;
            cy_ff <= e_ff[14] ? -QUARTER_TURN : QUARTER_TURN;
         end
         OP_DIV_MUL: begin
            quo_ff <= {1'b0, div_hi};
            rem_ff <= div_lo;
         end
         OP_DIV_RCP: begin
            quo_ff <= quo_ff + {19'd0, rcp_p[44:32]};
         end
         OP_SC_INIT: begin
            cx_ff <= 34'(INV_GAIN_Q30);
            cy_ff <= '0;
            cz_ff <= e_ff[14] ? -qz : qz;
         end
         OP_SC_STEP: begin
            if (!cz_ff[33]) begin
               cx_ff <= cx_ff - shy;
               cy_ff <= cy_ff + shx;
               cz_ff <= cz_ff - atan_s;
            end else begin
               cx_ff <= cx_ff + shy;
               cy_ff <= cy_ff - shx;
               cz_ff <= cz_ff + atan_s;
            end
         end
         OP_MULX: begin
            prod_ff <= mul_p;
         end
         OP_MULY: begin
            x4_ff   <= x4_full[31:0];
            prod_ff <= mul_p;
         end
         OP_ROUNDY: begin
            y4_ff     <= y4_full[31:0];
            origin_ff <= origin_in;
         end
         OP_VEC_INIT: begin
            // pre-rotate a point behind the centre by a quarter turn
            if (va < 0) begin
               if (vb >= 0) begin
                  cx_ff <= vb;
                  cy_ff <= -va;
                  cz_ff <= QUARTER_TURN;
               end else begin
                  cx_ff <= -vb;
                  cy_ff <= va;
                  cz_ff <= -QUARTER_TURN;
               end
            end else begin
               cx_ff <= va;
               cy_ff <= vb;
               cz_ff <= '0;
            end
         end
         OP_VEC_STEP: begin
            if (!cy_ff[33]) begin
               cx_ff <= cx_ff + shy;
               cy_ff <= cy_ff - shx;
               cz_ff <= cz_ff + atan_s;
            end else begin
               cx_ff <= cx_ff - shy;
               cy_ff <= cy_ff + shx;
               cz_ff <= cz_ff - atan_s;
            end
         end
         OP_MAG: begin
            prod_ff <= mul_p;
         end
         OP_ANG: begin
            hmag_ff <= hm_full[31:0];
            prod_ff <= mul_p;
         end
         OP_TRND: begin
            t_ff <= t_full[36:0];
         end
         OP_GR: begin
            prod_ff <= mul_p;
         end
         OP_FIN: begin
            slant_range_m <= s_ff;
            if (s_ff == '0) begin
               ground_range_m <= '0;
               height_m       <= '0;
            end else if (origin_ff) begin
               ground_range_m <= s_ff;
               height_m       <= '0;
            end else begin
               ground_range_m <= gr_sat;
               height_m       <= ht_sat;
            end
         end
         default: begin
         end
      endcase
   end

   assign status.zero_slant = (s_ff == '0);
   assign status.vertical   = (e_ff == ELEV_MAX) || (e_ff == ELEV_MIN);
   assign status.origin     = origin_ff;

endmodule
`default_nettype wire
